// ===== rtl/core/twep_pkg.sv =====
// Shared types and constants for the triangle weakest-edge pruner.
// Used by the channel interfaces, the compare unit and the top level.
package twep_pkg;

  localparam int unsigned MAX_REGULATORS_DEF = 64;
  localparam int unsigned MAX_GENES_DEF      = 1024;

  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned REG_W      = 6;
  localparam int unsigned GENE_W     = 10;
  localparam int unsigned WEIGHT_W   = 32;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned NR_W       = 7;
  localparam int unsigned NG_W       = 11;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [NR_W-1:0] NR_RESET = 7'd64;
  localparam logic [NG_W-1:0] NG_RESET = 11'd1024;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR     = 3'd0,
    ACT_LOAD_EDGE = 3'd1,
    ACT_LOAD_PAIR = 3'd2,
    ACT_PRUNE     = 3'd3,
    ACT_READ      = 3'd4
  } action_e;

  typedef enum logic {
    CFG_NUM_REGS  = 1'b0,
    CFG_NUM_GENES = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DEC_MARK1   = 2'd0,
    DEC_MARK2   = 2'd1,
    DEC_BOTH_RR = 2'd2
  } decide_e;

  typedef struct packed {
    logic                status;
    logic                present;
    logic                kept;
    logic [WEIGHT_W-1:0] edge_weight;
  } result_t;

endpackage

// ===== rtl/core/twep_if.sv =====
// Valid/ready channel interfaces for the pruner's item and result streams.
// Depends on twep_pkg for field widths.
interface twep_in_if;
  logic                             valid;
  logic                             ready;
  logic [twep_pkg::ACTION_W-1:0]    action;
  logic [twep_pkg::REG_W-1:0]       regulator;
  logic [twep_pkg::GENE_W-1:0]      gene;
  logic [twep_pkg::WEIGHT_W-1:0]    weight;
  modport source (output valid, action, regulator, gene, weight, input ready);
  modport sink   (input valid, action, regulator, gene, weight, output ready);
endinterface

interface twep_out_if;
  logic                             valid;
  logic                             ready;
  logic                             status;
  logic                             present;
  logic                             kept;
  logic [twep_pkg::WEIGHT_W-1:0]    edge_weight;
  logic [twep_pkg::COUNT_W-1:0]     removed_count;
  modport source (output valid, status, present, kept, edge_weight, removed_count,
                  input ready);
  modport sink   (input valid, status, present, kept, edge_weight, removed_count,
                  output ready);
endinterface

// ===== rtl/core/twep_mem.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependency.
module twep_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/core/twep_decide.sv =====
// Compare unit: picks which edge of a triangle to mark.
// Depends on twep_pkg for the decision codes.
module twep_decide (
  input  logic [twep_pkg::WEIGHT_W-1:0] v1_i,
  input  logic [twep_pkg::WEIGHT_W-1:0] v2_i,
  input  logic [twep_pkg::WEIGHT_W-1:0] pw_i,
  output twep_pkg::decide_e             dec_o
);

  always_comb begin
    if (v1_i < pw_i && v1_i < v2_i) begin
      dec_o = twep_pkg::DEC_MARK1;
    end else if (v2_i < pw_i && v2_i < v1_i) begin
      dec_o = twep_pkg::DEC_MARK2;
    end else begin
      dec_o = twep_pkg::DEC_BOTH_RR;
    end
  end

endmodule

// ===== rtl/core/triangle_weakest_edge_pruner.sv =====
// Triangle weakest-edge pruner. Load and unknown items go straight to the result handoff;
// a read passes through S_RD first. Prune clears all marks, walks each regulator pair
// and, for each weighted pair, every gene (one edge RAM read port means two reads per
// gene), then counts the marked edges. Clear is a sweep through all stores.
// Reset runs the same clearing sweep; no item is taken until it ends.
// Sequential: one item at a time; the result register frees the input side.
module triangle_weakest_edge_pruner #(
  parameter int unsigned MAX_REGULATORS = twep_pkg::MAX_REGULATORS_DEF,
  parameter int unsigned MAX_GENES      = twep_pkg::MAX_GENES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [twep_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  twep_in_if.sink                           in_i,
  twep_out_if.source                        out_o
);

  localparam int unsigned EDEPTH = MAX_REGULATORS * MAX_GENES;
  localparam int unsigned PDEPTH = MAX_REGULATORS * MAX_REGULATORS;
  localparam int unsigned SDEPTH = (EDEPTH > PDEPTH) ? EDEPTH : PDEPTH;
  localparam int unsigned EAW    = $clog2(EDEPTH);
  localparam int unsigned PAW    = $clog2(PDEPTH);
  localparam int unsigned SW     = $clog2(SDEPTH);
  localparam int unsigned RCW    = ($clog2(MAX_REGULATORS + 1) > twep_pkg::NR_W) ?
                                   $clog2(MAX_REGULATORS + 1) : twep_pkg::NR_W;
  localparam int unsigned GCW    = ($clog2(MAX_GENES + 1) > twep_pkg::NG_W) ?
                                   $clog2(MAX_GENES + 1) : twep_pkg::NG_W;
  localparam int unsigned WW     = twep_pkg::WEIGHT_W;
  localparam int unsigned CW     = twep_pkg::COUNT_W;

  typedef enum logic [12:0] {
    S_CLR  = 13'b0000000000001,
    S_IDLE = 13'b0000000000010,
    S_RD   = 13'b0000000000100,
    S_DONE = 13'b0000000001000,
    S_MCLR = 13'b0000000010000,
    S_PAIR = 13'b0000000100000,
    S_PCHK = 13'b0000001000000,
    S_E1   = 13'b0000010000000,
    S_E2   = 13'b0000100000000,
    S_CMP  = 13'b0001000000000,
    S_RR2  = 13'b0010000000000,
    S_CNT  = 13'b0100000000000,
    S_CNTW = 13'b1000000000000
  } state_e;

  function automatic logic [EAW-1:0] eaddr(logic [RCW-1:0] r, logic [GCW-1:0] g);
    eaddr = EAW'(r) * EAW'(MAX_GENES) + EAW'(g);
  endfunction

  function automatic logic [PAW-1:0] paddr(logic [RCW-1:0] lo, logic [RCW-1:0] hi);
    paddr = PAW'(lo) * PAW'(MAX_REGULATORS) + PAW'(hi);
  endfunction

  // configuration
  logic [twep_pkg::NR_W-1:0] nr_q;
  logic [twep_pkg::NG_W-1:0] ng_q;
  logic [RCW-1:0]            nr_use;
  logic [GCW-1:0]            ng_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nr_q <= twep_pkg::NR_RESET;
      ng_q <= twep_pkg::NG_RESET;
    end else if (cfg_we_i) begin
      if (twep_pkg::cfg_idx_e'(cfg_idx_i) == twep_pkg::CFG_NUM_REGS) begin
        nr_q <= cfg_wdata_i[twep_pkg::NR_W-1:0];
      end else begin
        ng_q <= cfg_wdata_i[twep_pkg::NG_W-1:0];
      end
    end
  end

  assign nr_use = (RCW'(nr_q) < RCW'(MAX_REGULATORS)) ? RCW'(nr_q) : RCW'(MAX_REGULATORS);
  assign ng_use = (GCW'(ng_q) < GCW'(MAX_GENES)) ? GCW'(ng_q) : GCW'(MAX_GENES);

  // stores: edge {valid, weight}, removal marks, pair {valid, weight}
  logic           edge_we, edge_re, mark_we, mark_wdata, mark_re, mark_rdata;
  logic           pair_we, pair_re;
  logic [EAW-1:0] edge_waddr, edge_raddr, mark_waddr, mark_raddr;
  logic [PAW-1:0] pair_waddr, pair_raddr;
  logic [WW:0]    edge_wdata, edge_rdata, pair_wdata, pair_rdata;

  twep_mem #(.DEPTH(EDEPTH), .WIDTH(WW + 1)) u_edge_mem (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .re_i(edge_re), .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );

  twep_mem #(.DEPTH(EDEPTH), .WIDTH(1)) u_mark_mem (
    .clk_i, .we_i(mark_we), .waddr_i(mark_waddr), .wdata_i(mark_wdata),
    .re_i(mark_re), .raddr_i(mark_raddr), .rdata_o(mark_rdata)
  );

  twep_mem #(.DEPTH(PDEPTH), .WIDTH(WW + 1)) u_pair_mem (
    .clk_i, .we_i(pair_we), .waddr_i(pair_waddr), .wdata_i(pair_wdata),
    .re_i(pair_re), .raddr_i(pair_raddr), .rdata_o(pair_rdata)
  );

  // sequencer state
  state_e             state_q, state_d;
  logic [SW-1:0]      sweep_q, sweep_d;
  logic [RCW-1:0]     r1_q, r1_d, r2_q, r2_d;
  logic [GCW-1:0]     g_q, g_d;
  logic [WW-1:0]      pw_q, pw_d, v1_q, v1_d;
  logic               e1v_q, e1v_d, cv_q, cv_d, resp_q, resp_d;
  logic [CW-1:0]      acc_q, acc_d, total_q, total_d;
  twep_pkg::result_t  res_q, res_d;
  logic               ov_q, ov_d;
  twep_pkg::result_t  out_q, out_d;
  logic [CW-1:0]      cnt_out_q, cnt_out_d;

  twep_pkg::decide_e  dec;
  twep_decide u_decide (.v1_i(v1_q), .v2_i(edge_rdata[WW-1:0]), .pw_i(pw_q), .dec_o(dec));

  logic [RCW-1:0] in_reg, in_gene_r, lo_r, hi_r;
  logic [GCW-1:0] in_gene;
  logic           edge_ok, pair_ok, gene_more, r2_more, r1_more, hit;

  assign in_reg    = RCW'(in_i.regulator);
  assign in_gene   = GCW'(in_i.gene);
  assign in_gene_r = RCW'(in_i.gene);
  assign edge_ok   = (32'(in_i.regulator) < 32'(nr_use)) && (32'(in_i.gene) < 32'(ng_use));
  assign pair_ok   = (32'(in_i.regulator) < 32'(nr_use)) && (32'(in_i.gene) < 32'(nr_use))
                     && (32'(in_i.regulator) != 32'(in_i.gene));
  assign lo_r      = (32'(in_i.regulator) < 32'(in_i.gene)) ? in_reg : in_gene_r;
  assign hi_r      = (32'(in_i.regulator) < 32'(in_i.gene)) ? in_gene_r : in_reg;
  assign gene_more = (g_q + GCW'(1)) < ng_use;
  assign r2_more   = (r2_q + RCW'(1)) < nr_use;
  assign r1_more   = (r1_q + RCW'(2)) < nr_use;
  assign hit       = cv_q && edge_rdata[WW] && mark_rdata;

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = ov_q;
  assign out_o.status       = out_q.status;
  assign out_o.present      = out_q.present;
  assign out_o.kept         = out_q.kept;
  assign out_o.edge_weight  = out_q.edge_weight;
  assign out_o.removed_count = cnt_out_q;

  always_comb begin
    state_d   = state_q;
    sweep_d   = sweep_q;
    r1_d      = r1_q;
    r2_d      = r2_q;
    g_d       = g_q;
    pw_d      = pw_q;
    v1_d      = v1_q;
    e1v_d     = e1v_q;
    cv_d      = cv_q;
    resp_d    = resp_q;
    acc_d     = acc_q;
    total_d   = total_q;
    res_d     = res_q;
    ov_d      = ov_q && !out_o.ready;
    out_d     = out_q;
    cnt_out_d = cnt_out_q;

    edge_we    = 1'b0;
    edge_waddr = eaddr(in_reg, in_gene);
    edge_wdata = {1'b1, in_i.weight};
    edge_re    = 1'b0;
    edge_raddr = eaddr(in_reg, in_gene);
    mark_we    = 1'b0;
    mark_waddr = eaddr(in_reg, in_gene);
    mark_wdata = 1'b0;
    mark_re    = 1'b0;
    mark_raddr = eaddr(in_reg, in_gene);
    pair_we    = 1'b0;
    pair_waddr = paddr(lo_r, hi_r);
    pair_wdata = {1'b1, in_i.weight};
    pair_re    = 1'b0;
    pair_raddr = paddr(r1_q, r2_q);

    unique case (state_q)
      S_CLR: begin
        edge_we    = (32'(sweep_q) < EDEPTH);
        edge_waddr = EAW'(sweep_q);
        edge_wdata = '0;
        mark_we    = (32'(sweep_q) < EDEPTH);
        mark_waddr = EAW'(sweep_q);
        pair_we    = (32'(sweep_q) < PDEPTH);
        pair_waddr = PAW'(sweep_q);
        pair_wdata = '0;
        sweep_d    = sweep_q + SW'(1);
        if (sweep_q == SW'(SDEPTH - 1)) begin
          state_d = resp_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_i.valid) begin
          res_d   = '0;
          state_d = S_DONE;
          unique case (twep_pkg::action_e'(in_i.action))
            twep_pkg::ACT_CLEAR: begin
              total_d = '0;
              sweep_d = '0;
              resp_d  = 1'b1;
              state_d = S_CLR;
            end
            twep_pkg::ACT_LOAD_EDGE: begin
              edge_we      = edge_ok;
              mark_we      = edge_ok;
              res_d.status = !edge_ok;
            end
            twep_pkg::ACT_LOAD_PAIR: begin
              pair_we      = pair_ok;
              res_d.status = !pair_ok;
            end
            twep_pkg::ACT_PRUNE: begin
              sweep_d = '0;
              state_d = S_MCLR;
            end
            twep_pkg::ACT_READ: begin
              edge_re      = 1'b1;
              mark_re      = 1'b1;
              res_d.status = !edge_ok;
              state_d      = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (!res_q.status && edge_rdata[WW]) begin
          res_d.present     = 1'b1;
          res_d.kept        = !mark_rdata;
          res_d.edge_weight = edge_rdata[WW-1:0];
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || out_o.ready) begin
          ov_d      = 1'b1;
          out_d     = res_q;
          cnt_out_d = total_q;
          resp_d    = 1'b0;
          state_d   = S_IDLE;
        end
      end
      S_MCLR: begin
        mark_we    = 1'b1;
        mark_waddr = EAW'(sweep_q);
        sweep_d    = sweep_q + SW'(1);
        if (sweep_q == SW'(EDEPTH - 1)) begin
          sweep_d = '0;
          cv_d    = 1'b0;
          acc_d   = '0;
          r1_d    = '0;
          r2_d    = RCW'(1);
          state_d = (RCW'(1) < nr_use) ? S_PAIR : S_CNT;
        end
      end
      S_PAIR: begin
        pair_re = 1'b1;
        state_d = S_PCHK;
      end
      S_PCHK: begin
        if (pair_rdata[WW] && ng_use != '0) begin
          pw_d    = pair_rdata[WW-1:0];
          g_d     = '0;
          state_d = S_E1;
        end else if (r2_more) begin
          r2_d    = r2_q + RCW'(1);
          state_d = S_PAIR;
        end else if (r1_more) begin
          r1_d    = r1_q + RCW'(1);
          r2_d    = r1_q + RCW'(2);
          state_d = S_PAIR;
        end else begin
          state_d = S_CNT;
        end
      end
      S_E1: begin
        edge_re    = 1'b1;
        edge_raddr = eaddr(r1_q, g_q);
        state_d    = S_E2;
      end
      S_E2: begin
        v1_d       = edge_rdata[WW-1:0];
        e1v_d      = edge_rdata[WW];
        edge_re    = 1'b1;
        edge_raddr = eaddr(r2_q, g_q);
        state_d    = S_CMP;
      end
      S_CMP, S_RR2: begin
        if (state_q == S_CMP && e1v_q && edge_rdata[WW] && dec == twep_pkg::DEC_BOTH_RR) begin
          // second regulator-to-regulator mark goes out next cycle
          mark_we    = (32'(r2_q) < MAX_GENES);
          mark_waddr = eaddr(r1_q, GCW'(r2_q));
          mark_wdata = 1'b1;
          state_d    = S_RR2;
        end else begin
          if (state_q == S_RR2) begin
            mark_we    = (32'(r1_q) < MAX_GENES);
            mark_waddr = eaddr(r2_q, GCW'(r1_q));
            mark_wdata = 1'b1;
          end else if (e1v_q && edge_rdata[WW]) begin
            mark_we    = 1'b1;
            mark_wdata = 1'b1;
            mark_waddr = (dec == twep_pkg::DEC_MARK1) ? eaddr(r1_q, g_q) : eaddr(r2_q, g_q);
          end
          if (gene_more) begin
            g_d     = g_q + GCW'(1);
            state_d = S_E1;
          end else if (r2_more) begin
            r2_d    = r2_q + RCW'(1);
            state_d = S_PAIR;
          end else if (r1_more) begin
            r1_d    = r1_q + RCW'(1);
            r2_d    = r1_q + RCW'(2);
            state_d = S_PAIR;
          end else begin
            state_d = S_CNT;
          end
        end
      end
      S_CNT: begin
        edge_re    = 1'b1;
        edge_raddr = EAW'(sweep_q);
        mark_re    = 1'b1;
        mark_raddr = EAW'(sweep_q);
        cv_d       = 1'b1;
        acc_d      = acc_q + CW'(hit);
        sweep_d    = sweep_q + SW'(1);
        if (sweep_q == SW'(EDEPTH - 1)) begin
          state_d = S_CNTW;
        end
      end
      S_CNTW: begin
        total_d = acc_q + CW'(hit);
        res_d   = '0;
        state_d = S_DONE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      sweep_q <= '0;
      resp_q  <= 1'b0;
      ov_q    <= 1'b0;
      total_q <= '0;
      cv_q    <= 1'b0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      resp_q  <= resp_d;
      ov_q    <= ov_d;
      total_q <= total_d;
      cv_q    <= cv_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q      <= r1_d;
    r2_q      <= r2_d;
    g_q       <= g_d;
    pw_q      <= pw_d;
    v1_q      <= v1_d;
    e1v_q     <= e1v_d;
    res_q     <= res_d;
    out_q     <= out_d;
    cnt_out_q <= cnt_out_d;
  end

  // a new result appears only from the handoff state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !$past(ov_q && !out_o.ready)) |-> $past(state_q == S_DONE))
    else $error("result loaded outside handoff");

  // prune walk keeps r1 < r2 < regulators in use
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_E1 || state_q == S_PAIR) |-> (r1_q < r2_q && r2_q < nr_use))
    else $error("regulator pair out of order");

  // marks are set only by the prune compare
  a_mark_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mark_we && mark_wdata) |-> (state_q == S_CMP || state_q == S_RR2))
    else $error("mark set outside prune");

  // the count pass ends with the total written before handoff
  a_cnt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CNTW) |=> (state_q == S_DONE && total_q == $past(acc_q + CW'(hit))))
    else $error("count handoff broken");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for triangle_weakest_edge_pruner: edge/pair loads,
// prune, read and clear items with a predictor and a result scoreboard.
// Depends on twep_pkg and the twep_in_if / twep_out_if channel interfaces.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned MAXR = twep_pkg::MAX_REGULATORS_DEF;
  localparam int unsigned MAXG = twep_pkg::MAX_GENES_DEF;
  localparam logic [twep_pkg::ACTION_W-1:0] ACT_RSVD_LO = 3'd5;
  localparam logic [twep_pkg::ACTION_W-1:0] ACT_RSVD_HI = 3'd7;
  localparam int unsigned RAND_ITEMS = 100;

  typedef struct {
    logic [twep_pkg::ACTION_W-1:0] action;
    logic [twep_pkg::REG_W-1:0]    regulator;
    logic [twep_pkg::GENE_W-1:0]   gene;
    logic [twep_pkg::WEIGHT_W-1:0] weight;
  } item_t;

  typedef struct {
    logic                          status;
    logic                          present;
    logic                          kept;
    logic [twep_pkg::WEIGHT_W-1:0] edge_weight;
    logic [twep_pkg::COUNT_W-1:0]  removed_count;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [twep_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  twep_in_if  in_ch ();
  twep_out_if out_ch ();

  triangle_weakest_edge_pruner u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // predictor state
  bit              edge_ok [MAXR*MAXG];
  bit [31:0]       edge_w  [MAXR*MAXG];
  bit              pair_ok [MAXR*MAXR];
  bit [31:0]       pair_w  [MAXR*MAXR];
  bit              cut_mark[MAXR*MAXG];
  bit [twep_pkg::COUNT_W-1:0] cut_total;
  int unsigned     cfg_nr, cfg_ng;

  item_t    pending_q[$];
  verdict_t expected_q[$];
  item_t    cur;
  int       errors;
  int       n_by_action[8];
  int       n_results;
  int       gap_cnt, burst_cnt;
  int       stall_cnt, stall_mode;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned regs_live();
    return (cfg_nr < MAXR) ? cfg_nr : MAXR;
  endfunction

  function automatic int unsigned genes_live();
    return (cfg_ng < MAXG) ? cfg_ng : MAXG;
  endfunction

  function automatic void wipe_stores();
    for (int i = 0; i < MAXR*MAXG; i++) begin
      edge_ok[i]  = 1'b0;
      cut_mark[i] = 1'b0;
    end
    for (int i = 0; i < MAXR*MAXR; i++) pair_ok[i] = 1'b0;
    cut_total = '0;
  endfunction

  function automatic void prune_triangles();
    int unsigned nr, ng, e1, e2, cnt;
    bit [31:0] pw, v1, v2;
    nr = regs_live();
    ng = genes_live();
    cnt = 0;
    for (int i = 0; i < MAXR*MAXG; i++) cut_mark[i] = 1'b0;
    for (int unsigned r1 = 0; r1 < nr; r1++) begin
      for (int unsigned r2 = r1 + 1; r2 < nr; r2++) begin
        if (pair_ok[r1*MAXR + r2]) begin
          pw = pair_w[r1*MAXR + r2];
          for (int unsigned g = 0; g < ng; g++) begin
            e1 = r1*MAXG + g;
            e2 = r2*MAXG + g;
            if (edge_ok[e1] && edge_ok[e2]) begin
              v1 = edge_w[e1];
              v2 = edge_w[e2];
              if (v1 < pw && v1 < v2) cut_mark[e1] = 1'b1;
              else if (v2 < pw && v2 < v1) cut_mark[e2] = 1'b1;
              else begin
                // tie or no strict weakest: drop the regulator-regulator edges
                if (r2 < MAXG) cut_mark[r1*MAXG + r2] = 1'b1;
                if (r1 < MAXG) cut_mark[r2*MAXG + r1] = 1'b1;
              end
            end
          end
        end
      end
    end
    for (int i = 0; i < MAXR*MAXG; i++) if (edge_ok[i] && cut_mark[i]) cnt++;
    cut_total = cnt[twep_pkg::COUNT_W-1:0];
  endfunction

  function automatic verdict_t predict_item(item_t it);
    verdict_t v;
    int unsigned nr, ng, e, lo, hi;
    nr = regs_live();
    ng = genes_live();
    v = '{default: '0};
    case (it.action)
      twep_pkg::ACT_CLEAR: wipe_stores();
      twep_pkg::ACT_LOAD_EDGE: begin
        if (it.regulator < nr && it.gene < ng) begin
          e = it.regulator*MAXG + it.gene;
          edge_w[e] = it.weight;
          edge_ok[e] = 1'b1;
          cut_mark[e] = 1'b0;
        end else v.status = 1'b1;
      end
      twep_pkg::ACT_LOAD_PAIR: begin
        if (it.regulator < nr && it.gene < nr && it.regulator != it.gene) begin
          lo = (it.regulator < it.gene) ? it.regulator : it.gene;
          hi = (it.regulator < it.gene) ? it.gene : it.regulator;
          pair_w[lo*MAXR + hi] = it.weight;
          pair_ok[lo*MAXR + hi] = 1'b1;
        end else v.status = 1'b1;
      end
      twep_pkg::ACT_PRUNE: prune_triangles();
      twep_pkg::ACT_READ: begin
        if (it.regulator < nr && it.gene < ng) begin
          e = it.regulator*MAXG + it.gene;
          if (edge_ok[e]) begin
            v.present = 1'b1;
            v.kept = !cut_mark[e];
            v.edge_weight = edge_w[e];
          end
        end else v.status = 1'b1;
      end
      default: ;
    endcase
    v.removed_count = cut_total;
    return v;
  endfunction

  // driver: bursts of transfers separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    bit fire, drive;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      gap_cnt <= 0;
      burst_cnt <= 1;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        expected_q.push_back(predict_item(cur));
        n_by_action[cur.action]++;
      end
      drive = in_ch.valid && !fire;
      if (!drive) begin
        if (gap_cnt > 0) gap_cnt <= gap_cnt - 1;
        else if (pending_q.size() > 0) begin
          cur = pending_q.pop_front();
          drive = 1'b1;
          if (burst_cnt <= 1) begin
            burst_cnt <= $urandom_range(1, 12);
            gap_cnt <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else burst_cnt <= burst_cnt - 1;
        end
      end
      in_ch.valid     <= drive;
      in_ch.action    <= cur.action;
      in_ch.regulator <= cur.regulator;
      in_ch.gene      <= cur.gene;
      in_ch.weight    <= cur.weight;
    end
  end

  // monitor: receiver stalls follow a mode that is re-picked at random over time
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t exp_v;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_cnt <= 0;
      stall_mode <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected (count %0d)", $time,
                   out_ch.removed_count);
        end else begin
          exp_v = expected_q.pop_front();
          if (out_ch.status !== exp_v.status) begin
            errors++;
            $display("%0t: status exp %0d got %0d", $time, exp_v.status, out_ch.status);
          end
          if (out_ch.present !== exp_v.present) begin
            errors++;
            $display("%0t: present exp %0d got %0d", $time, exp_v.present, out_ch.present);
          end
          if (out_ch.kept !== exp_v.kept) begin
            errors++;
            $display("%0t: kept exp %0d got %0d", $time, exp_v.kept, out_ch.kept);
          end
          if (out_ch.edge_weight !== exp_v.edge_weight) begin
            errors++;
            $display("%0t: edge_weight exp %h got %h", $time, exp_v.edge_weight,
                     out_ch.edge_weight);
          end
          if (out_ch.removed_count !== exp_v.removed_count) begin
            errors++;
            $display("%0t: removed_count exp %0d got %0d", $time, exp_v.removed_count,
                     out_ch.removed_count);
          end
        end
      end
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt % 64 == 63) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= $urandom_range(0, 1);
        default: out_ch.ready <= (stall_cnt % 4 != 0);
      endcase
    end
  end

  function automatic item_t mk(logic [twep_pkg::ACTION_W-1:0] a, int unsigned r,
                               int unsigned g, logic [31:0] w);
    item_t it;
    it.action = a;
    it.regulator = r[twep_pkg::REG_W-1:0];
    it.gene = g[twep_pkg::GENE_W-1:0];
    it.weight = w;
    return it;
  endfunction

  function automatic logic [31:0] pick_weight();
    // coarse values make ties and pair-threshold hits common
    if ($urandom_range(0, 1) == 0) return 32'($urandom_range(0, 3)) << 24;
    return $urandom;
  endfunction

  function automatic item_t rand_item();
    int unsigned pick, nr, ng;
    nr = regs_live();
    ng = genes_live();
    pick = $urandom_range(0, 99);
    if (pick < 2) return mk(twep_pkg::ACT_CLEAR, 0, 0, $urandom);
    if (pick < 7) return mk(twep_pkg::ACT_PRUNE, $urandom, $urandom, $urandom);
    if (pick < 9) return mk($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI), $urandom, $urandom,
                            $urandom);
    if (pick < 15)
      return mk($urandom_range(twep_pkg::ACT_LOAD_EDGE, twep_pkg::ACT_READ), $urandom,
                $urandom, $urandom);
    if (pick < 55)
      return mk(twep_pkg::ACT_LOAD_EDGE, $urandom_range(0, nr-1), $urandom_range(0, ng-1),
                pick_weight());
    if (pick < 68)
      return mk(twep_pkg::ACT_LOAD_PAIR, $urandom_range(0, nr-1), $urandom_range(0, nr-1),
                pick_weight());
    return mk(twep_pkg::ACT_READ, $urandom_range(0, nr-1), $urandom_range(0, ng-1),
              $urandom);
  endfunction

  task automatic wait_idle();
    while (pending_q.size() != 0 || in_ch.valid || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(twep_pkg::cfg_idx_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val[twep_pkg::CFG_DATA_W-1:0];
    if (idx == twep_pkg::CFG_NUM_REGS) cfg_nr = val & 32'h7F;
    else cfg_ng = val & 32'h7FF;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = '0;
    in_ch.regulator = '0;
    in_ch.gene = '0;
    in_ch.weight = '0;
    out_ch.ready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = twep_pkg::CFG_NUM_REGS;
    cfg_wdata_i = '0;
    cur = mk(twep_pkg::ACT_CLEAR, 0, 0, 0);
    errors = 0;
    n_results = 0;
    cfg_nr = twep_pkg::NR_RESET;
    cfg_ng = twep_pkg::NG_RESET;
    wipe_stores();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full-size settings, written above the clamp
    write_cfg(twep_pkg::CFG_NUM_REGS, 127);
    write_cfg(twep_pkg::CFG_NUM_GENES, 2047);
    pending_q.push_back(mk(twep_pkg::ACT_READ, 63, 1023, 0));
    pending_q.push_back(mk(twep_pkg::ACT_LOAD_EDGE, 0, 5, 32'h0000_0000));
    pending_q.push_back(mk(twep_pkg::ACT_LOAD_EDGE, 1, 5, 32'hFFFF_FFFF));
    pending_q.push_back(mk(twep_pkg::ACT_LOAD_EDGE, 63, 1023, 32'hFFFF_FFFF));
    pending_q.push_back(mk(twep_pkg::ACT_LOAD_EDGE, 0, 1, 32'h8000_0000));
    pending_q.push_back(mk(twep_pkg::ACT_LOAD_EDGE, 1, 0, 32'h8000_0000));
    pending_q.push_back(mk(twep_pkg::ACT_LOAD_EDGE, 0, 7, 32'h0000_0100));
    pending_q.push_back(mk(twep_pkg::ACT_LOAD_EDGE, 1, 7, 32'h0000_0100));
    pending_q.push_back(mk(twep_pkg::ACT_LOAD_PAIR, 1, 0, 32'h9000_0000));
    pending_q.push_back(mk(twep_pkg::ACT_LOAD_PAIR, 3, 3, 32'h1234_5678));
    pending_q.push_back(mk(twep_pkg::ACT_LOAD_PAIR, 0, 64, 32'h1));
    pending_q.push_back(mk(twep_pkg::ACT_PRUNE, 0, 0, 0));
    pending_q.push_back(mk(twep_pkg::ACT_READ, 0, 5, 0));
    pending_q.push_back(mk(twep_pkg::ACT_READ, 1, 5, 0));
    pending_q.push_back(mk(twep_pkg::ACT_READ, 0, 1, 0));
    pending_q.push_back(mk(twep_pkg::ACT_READ, 63, 1023, 0));
    pending_q.push_back(mk(ACT_RSVD_LO, 63, 1023, 32'hFFFF_FFFF));
    pending_q.push_back(mk(ACT_RSVD_HI, 0, 0, 0));
    pending_q.push_back(mk(twep_pkg::ACT_CLEAR, 0, 0, 0));
    pending_q.push_back(mk(twep_pkg::ACT_READ, 0, 5, 0));
    wait_idle();

    // smallest settings: everything but id 0 is out of range
    write_cfg(twep_pkg::CFG_NUM_REGS, 1);
    write_cfg(twep_pkg::CFG_NUM_GENES, 1);
    pending_q.push_back(mk(twep_pkg::ACT_LOAD_EDGE, 0, 0, 32'hDEAD_BEEF));
    pending_q.push_back(mk(twep_pkg::ACT_LOAD_EDGE, 0, 1, 32'h1));
    pending_q.push_back(mk(twep_pkg::ACT_LOAD_EDGE, 1, 0, 32'h1));
    pending_q.push_back(mk(twep_pkg::ACT_LOAD_PAIR, 0, 1, 32'h1));
    pending_q.push_back(mk(twep_pkg::ACT_READ, 5, 0, 0));
    pending_q.push_back(mk(twep_pkg::ACT_PRUNE, 0, 0, 0));
    pending_q.push_back(mk(twep_pkg::ACT_READ, 0, 0, 0));
    wait_idle();

    // random phases with small size settings so the prune walk stays short
    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(twep_pkg::CFG_NUM_REGS, $urandom_range(2, 8));
      write_cfg(twep_pkg::CFG_NUM_GENES, $urandom_range(2, 24));
      for (int k = 0; k < RAND_ITEMS / 4; k++) pending_q.push_back(rand_item());
      wait_idle();
    end

    repeat (50) @(posedge clk_i);
    $display("Covered %0d results: clear %0d, edge load %0d, pair load %0d, prune %0d,",
             n_results, n_by_action[twep_pkg::ACT_CLEAR],
             n_by_action[twep_pkg::ACT_LOAD_EDGE], n_by_action[twep_pkg::ACT_LOAD_PAIR],
             n_by_action[twep_pkg::ACT_PRUNE]);
    $display("read %0d, reserved %0d, over six settings of the two size registers.",
             n_by_action[twep_pkg::ACT_READ],
             n_by_action[5] + n_by_action[6] + n_by_action[7]);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** triangle_weakest_edge_pruner: PASSED **");
    end else begin
      $display("** triangle_weakest_edge_pruner: FAILED **");
    end
    $finish;
  end

  // room for every item being a full-store prune or clear under stalls
  initial begin
    #(64'd1_000_000_000);
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("** triangle_weakest_edge_pruner: FAILED **");
    $finish;
  end

endmodule
